@@ hdl/ptm_pkg.sv @@
package ptm_pkg;

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // waveform codes (sine and triangle share the triangle path)
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_RELEASE = 2'd1;
    localparam logic [1:0] REG_PEAK    = 2'd2;
    localparam logic [1:0] REG_MAX_DUR = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // configuration reset values
    localparam logic [9:0]  RST_ATTACK  = 10'd80;
    localparam logic [9:0]  RST_RELEASE = 10'd180;
    localparam logic [13:0] RST_PEAK    = 14'd5200;
    localparam logic [11:0] RST_MAX_DUR = 12'd2500;

    // clamp limits: Q12.4 frequency 40..4000 Hz, minimum duration 10 ms
    localparam logic [15:0] FQ_MIN  = 16'd640;
    localparam logic [15:0] FQ_MAX  = 16'd64000;
    localparam logic [15:0] DUR_MIN = 16'd10;

    // phase step = fq * 2^28 / 16000 = fq * 16777 + fq * 27 / 125
    // fq * 27 / 125 = (fq * 27 * 2147484) >> 28, exact for fq * 27 < 2^21
    localparam logic [14:0] STEP_INT   = 15'd16777;
    localparam logic [4:0]  STEP_FRAC  = 5'd27;
    localparam logic [21:0] STEP_RECIP = 22'd2147484;
    localparam int          STEP_SHIFT = 28;

    // shared divider: dividend width and iteration counter width
    localparam int DIV_W  = 40;
    localparam int DIV_CW = 6;

    // command queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    typedef struct packed {
        logic [9:0]  attack;
        logic [9:0]  release_len;
        logic [13:0] peak;
        logic [11:0] max_dur;
    } t_cfg;

    // classified command from the front end
    typedef struct packed {
        logic        op;
        logic [1:0]  wave;
        logic [15:0] fq;
        logic [15:0] total;
        logic [19:0] wait_cnt;
    } t_cmd;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [9:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hdl/ptm_if.sv @@
interface ptm_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [1:0]  waveform;
    logic [15:0] frequency_q4;
    logic [15:0] tone_len_ms;
    logic [15:0] lead_in_ms;

    modport source (output valid, operation, waveform, frequency_q4, tone_len_ms, lead_in_ms,
                    input ready);
    modport sink   (input valid, operation, waveform, frequency_q4, tone_len_ms, lead_in_ms,
                    output ready);
endinterface

interface ptm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               any_active;

    modport source (output valid, sample, any_active, input ready);
    modport sink   (input valid, sample, any_active, output ready);
endinterface

interface ptm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ptm_pkg::CFG_IDX_W-1:0]  index;
    logic [ptm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/ptm_front.sv @@
module ptm_front (
    input  ptm_pkg::t_cfg i_cfg,
    ptm_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output ptm_pkg::t_cmd o_cmd
);

    logic [15:0] w_dur_lo;
    logic [15:0] w_dur;

    // accept whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // clamp the word and convert to sample counts
    always_comb begin
        w_dur_lo = (i_in.tone_len_ms < ptm_pkg::DUR_MIN) ? ptm_pkg::DUR_MIN : i_in.tone_len_ms;
        w_dur    = (w_dur_lo > {4'd0, i_cfg.max_dur}) ? {4'd0, i_cfg.max_dur} : w_dur_lo;

        o_cmd.op   = i_in.operation;
        o_cmd.wave = i_in.waveform;
        if (i_in.frequency_q4 < ptm_pkg::FQ_MIN) begin
            o_cmd.fq = ptm_pkg::FQ_MIN;
        end else if (i_in.frequency_q4 > ptm_pkg::FQ_MAX) begin
            o_cmd.fq = ptm_pkg::FQ_MAX;
        end else begin
            o_cmd.fq = i_in.frequency_q4;
        end
        o_cmd.total    = {w_dur[11:0], 4'd0};
        o_cmd.wait_cnt = {i_in.lead_in_ms, 4'd0};
    end

endmodule

@@ hdl/ptm_fifo.sv @@
module ptm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ptm_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ptm_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    ptm_pkg::t_cmd                r_mem [ptm_pkg::FIFO_DEPTH];
    logic [ptm_pkg::FIFO_AW-1:0]  r_wr;
    logic [ptm_pkg::FIFO_AW-1:0]  r_rd;
    logic [ptm_pkg::FIFO_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (ptm_pkg::FIFO_AW+1)'(ptm_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hdl/ptm_div.sv @@
module ptm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptm_pkg::t_div_req i_req,
    output ptm_pkg::t_div_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [ptm_pkg::DIV_CW-1:0]   r_cnt;
    logic [9:0]                   r_rem;
    logic [ptm_pkg::DIV_W-1:0]    r_quo;
    logic [9:0]                   r_div;
    logic [10:0]                  w_trial;
    logic                         w_ge;
    logic [10:0]                  w_diff;

    // one restoring step: shift in the next dividend bit
    always_comb begin
        w_trial = {r_rem, r_quo[ptm_pkg::DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[9:0] : w_trial[9:0];
            r_quo <= {r_quo[ptm_pkg::DIV_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == ptm_pkg::DIV_CW'(ptm_pkg::DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

@@ hdl/ptm_back.sv @@
module ptm_back #(
    parameter int VOICES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptm_pkg::t_cfg     i_cfg,
    input  logic              i_empty,
    input  ptm_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output ptm_pkg::t_div_req o_req,
    input  ptm_pkg::t_div_rsp i_rsp,
    ptm_out_if.source         o_out
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST = VW'(VOICES - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_STEP = 4'd2;
    localparam logic [3:0] S_TV   = 4'd3;
    localparam logic [3:0] S_ATK  = 4'd4;
    localparam logic [3:0] S_RCHK = 4'd5;
    localparam logic [3:0] S_REL  = 4'd6;
    localparam logic [3:0] S_WAV  = 4'd7;
    localparam logic [3:0] S_WSH  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // voice table
    logic [VOICES-1:0] r_act;
    logic [1:0]        r_wave_m  [VOICES];
    logic [31:0]       r_phase_m [VOICES];
    logic [31:0]       r_step_m  [VOICES];
    logic [15:0]       r_total_m [VOICES];
    logic [15:0]       r_pos_m   [VOICES];
    logic [19:0]       r_wait_m  [VOICES];

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    ptm_pkg::t_cmd       r_cmd;
    logic [VW-1:0]       r_vidx;
    logic [VW-1:0]       r_slot;
    logic [20:0]         r_best;
    logic [20:0]         r_frac;
    logic signed [23:0]  r_acc;
    logic                r_any;
    logic [8:0]          r_level;
    logic [15:0]         r_rem;
    logic signed [31:0]  r_prod;
    logic signed [15:0]  r_wv;
    logic signed [25:0]  r_mix;
    logic                r_out_vld;
    logic signed [15:0]  r_sample;
    logic                r_out_any;

    // current voice fields
    logic               w_act;
    logic [1:0]         w_wave;
    logic [31:0]        w_phase;
    logic [15:0]        w_total;
    logic [15:0]        w_pos;
    logic [19:0]        w_wait;
    logic [15:0]        w_pos_inc;
    logic [20:0]        w_left;
    logic               w_last;
    logic               w_load;
    logic               w_add_go;
    logic               w_atk_go;
    logic [42:0]        w_frac_prod;
    logic [31:0]        w_step;
    logic signed [16:0] w_m;
    logic signed [15:0] w_amp;
    logic signed [31:0] w_saw;
    logic signed [15:0] w_tri_part;
    logic signed [25:0] w_mix_rnd;
    logic signed [23:0] w_contrib;
    logic signed [15:0] w_sat;

    always_comb begin
        w_act     = r_act[r_vidx];
        w_wave    = r_wave_m[r_vidx];
        w_phase   = r_phase_m[r_vidx];
        w_total   = r_total_m[r_vidx];
        w_pos     = r_pos_m[r_vidx];
        w_wait    = r_wait_m[r_vidx];
        w_pos_inc = w_pos + 16'd1;
        w_left    = {1'b0, w_wait} + ((w_total > w_pos) ? {5'd0, w_total - w_pos} : 21'd0);
        w_last    = (r_vidx == LAST);
        w_load    = (r_state == S_OUT) && (!r_out_vld || o_out.ready);
        w_add_go  = (r_state == S_IDLE) && !i_empty && (i_cmd.op == ptm_pkg::OP_ADD)
                    && (i_cmd.total != '0);
        w_atk_go  = (r_state == S_TV) && w_act && (w_wait == '0) && (w_pos < w_total)
                    && (w_pos < {6'd0, i_cfg.attack});
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // phase step: whole part by constant multiply, fraction by reciprocal
    always_comb begin
        w_frac_prod = 43'(r_frac) * 43'(ptm_pkg::STEP_RECIP);
        w_step      = 32'(r_cmd.fq) * 32'(ptm_pkg::STEP_INT)
                      + 32'(w_frac_prod >> ptm_pkg::STEP_SHIFT);
    end

    // divider requests: attack ramp, release ramp
    always_comb begin
        o_req.start    = w_atk_go
                         || ((r_state == S_RCHK) && (r_rem < {6'd0, i_cfg.release_len}));
        o_req.dividend = {16'd0, r_rem, 8'd0};
        o_req.divisor  = i_cfg.release_len;
        if (r_state == S_TV) begin
            o_req.dividend = {16'd0, w_pos, 8'd0};
            o_req.divisor  = i_cfg.attack;
        end
    end

    // waveform datapath pieces
    always_comb begin
        w_amp = $signed({2'b00, i_cfg.peak});
        if ((w_wave == ptm_pkg::WAVE_SAWTOOTH) || w_phase[31]) begin
            w_m = $signed({1'b0, w_phase[31:16]}) - 17'sd32768;
        end else begin
            w_m = $signed({1'b0, w_phase[31:16]});
        end
        // truncate toward zero on the sawtooth scale
        w_saw      = (r_prod + (r_prod[31] ? 32'sd32767 : 32'sd0)) >>> 15;
        w_tri_part = 16'(r_prod >>> 14);
        w_mix_rnd  = (r_mix + (r_mix[25] ? 26'sd255 : 26'sd0)) >>> 8;
        w_contrib  = 24'(w_mix_rnd);
        if (r_acc > 24'sd32767) begin
            w_sat = 16'sd32767;
        end else if (r_acc < -24'sd32768) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = 16'(r_acc);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.op == ptm_pkg::OP_TICK) begin
                        n_state = S_TV;
                    end else if (w_add_go) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!w_act || w_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: n_state = S_IDLE;
            S_TV: begin
                if (w_atk_go) begin
                    n_state = S_ATK;
                end else if (w_act && (w_wait == '0) && (w_pos < w_total)) begin
                    n_state = S_RCHK;
                end else if (w_last) begin
                    n_state = S_OUT;
                end
            end
            S_ATK: begin
                if (i_rsp.done) begin
                    n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                n_state = (r_rem < {6'd0, i_cfg.release_len}) ? S_REL : S_WAV;
            end
            S_REL: begin
                if (i_rsp.done) begin
                    n_state = S_WAV;
                end
            end
            S_WAV: n_state = S_WSH;
            S_WSH: n_state = S_MUL;
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = w_last ? S_OUT : S_TV;
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, datapath and voice table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_act     <= '0;
            r_out_vld <= 1'b0;
            r_vidx    <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_vld && o_out.ready && !w_load) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd  <= i_cmd;
                        r_frac <= 21'(i_cmd.fq) * 21'(ptm_pkg::STEP_FRAC);
                        r_vidx <= '0;
                        r_acc  <= '0;
                        r_any  <= 1'b0;
                        r_best <= '1;
                        r_slot <= '0;
                    end
                end
                S_SCAN: begin
                    if (!w_act) begin
                        r_slot <= r_vidx;
                    end else begin
                        if (w_left < r_best) begin
                            r_best <= w_left;
                            r_slot <= r_vidx;
                        end
                        if (!w_last) begin
                            r_vidx <= r_vidx + 1'b1;
                        end
                    end
                end
                S_STEP: begin
                    r_act[r_slot]     <= 1'b1;
                    r_wave_m[r_slot]  <= r_cmd.wave;
                    r_phase_m[r_slot] <= '0;
                    r_step_m[r_slot]  <= w_step;
                    r_total_m[r_slot] <= r_cmd.total;
                    r_pos_m[r_slot]   <= '0;
                    r_wait_m[r_slot]  <= r_cmd.wait_cnt;
                end
                S_TV: begin
                    r_rem   <= w_total - w_pos;
                    r_level <= 9'd256;
                    if (w_act && (w_wait != '0)) begin
                        r_wait_m[r_vidx] <= w_wait - 20'd1;
                        r_any            <= 1'b1;
                    end else if (w_act && (w_pos >= w_total)) begin
                        r_act[r_vidx] <= 1'b0;
                    end
                    if (!(w_act && (w_wait == '0) && (w_pos < w_total)) && !w_last) begin
                        r_vidx <= r_vidx + 1'b1;
                    end
                end
                S_ATK: begin
                    if (i_rsp.done) begin
                        r_level <= {1'b0, i_rsp.quotient[7:0]};
                    end
                end
                S_RCHK: begin
                end
                S_REL: begin
                    if (i_rsp.done && ({1'b0, i_rsp.quotient[7:0]} < r_level)) begin
                        r_level <= {1'b0, i_rsp.quotient[7:0]};
                    end
                end
                S_WAV: begin
                    r_prod <= w_m * $signed({1'b0, w_amp[14:0]});
                end
                S_WSH: begin
                    if (w_wave == ptm_pkg::WAVE_SQUARE) begin
                        r_wv <= w_phase[31] ? w_amp : -w_amp;
                    end else if (w_wave == ptm_pkg::WAVE_SAWTOOTH) begin
                        r_wv <= 16'(w_saw);
                    end else if (w_phase[31]) begin
                        r_wv <= w_amp - w_tri_part;
                    end else begin
                        r_wv <= w_tri_part - w_amp;
                    end
                end
                S_MUL: begin
                    r_mix <= r_wv * $signed({1'b0, r_level});
                end
                S_ACC: begin
                    r_acc              <= r_acc + w_contrib;
                    r_phase_m[r_vidx]  <= w_phase + r_step_m[r_vidx];
                    r_pos_m[r_vidx]    <= w_pos_inc;
                    if (w_pos_inc >= w_total) begin
                        r_act[r_vidx] <= 1'b0;
                    end else begin
                        r_any <= 1'b1;
                    end
                    if (!w_last) begin
                        r_vidx <= r_vidx + 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out_vld <= 1'b1;
                        r_sample  <= w_sat;
                        r_out_any <= r_any;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.sample     = r_sample;
    assign o_out.any_active = r_out_any;

    // divider is never restarted mid-division
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |-> !i_rsp.busy)
        else $error("divider started while busy");

    // a placed voice is live in the following cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |=> r_act[$past(r_slot)])
        else $error("added voice not active");

    // a finished tick lands in the output register and the sequencer frees up
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_vld && r_state == S_IDLE))
        else $error("tick result not registered");

    // only the idle sequencer takes words from the queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("queue popped while busy");

endmodule

@@ hdl/polyphonic_tone_mixer_unit.sv @@
// Polyphonic tone mixer: a table of VOICES phase-accumulator voices mixed to
// one saturated 16-bit sample per tick word.
// Channels: i_in takes words (operation 0 adds a tone, 1 renders a tick);
// o_out gives one word per tick (sample, any_active); i_cfg writes the
// attack, release, peak and max-duration registers (ready is always high).
// A two-entry command queue sits between the input classifier and the voice
// sequencer, so input words keep being taken while the sequencer works.
// Add: take the word, scan for a slot and write the table (the phase step
// comes from a reciprocal multiply); a duration that clamps to zero adds
// nothing. Tick: take the word, visit each voice in turn, render each
// sounding voice, each envelope ramp costing a pass of the shared serial
// divider, and load the result.
// A result is held in the output register while o_out.ready is low; the
// sequencer then waits with the next tick, and the queue fills and drops
// i_in.ready.
// Reset clears all voices, the queue and the output register and restores
// the register defaults; there is no clearing pass.
module polyphonic_tone_mixer_unit #(
    parameter int VOICES = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptm_in_if.sink     i_in,
    ptm_out_if.source  o_out,
    ptm_cfg_if.sink    i_cfg
);

    ptm_pkg::t_cfg     r_cfg;
    ptm_pkg::t_cmd     w_push_cmd;
    ptm_pkg::t_cmd     w_pop_cmd;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    ptm_pkg::t_div_req w_req;
    ptm_pkg::t_div_rsp w_rsp;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack      <= ptm_pkg::RST_ATTACK;
            r_cfg.release_len <= ptm_pkg::RST_RELEASE;
            r_cfg.peak        <= ptm_pkg::RST_PEAK;
            r_cfg.max_dur     <= ptm_pkg::RST_MAX_DUR;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ptm_pkg::REG_ATTACK:  r_cfg.attack      <= i_cfg.data[9:0];
                ptm_pkg::REG_RELEASE: r_cfg.release_len <= i_cfg.data[9:0];
                ptm_pkg::REG_PEAK:    r_cfg.peak        <= i_cfg.data[13:0];
                ptm_pkg::REG_MAX_DUR: r_cfg.max_dur     <= i_cfg.data[11:0];
                default: begin
                end
            endcase
        end
    end

    ptm_front u_front (
        .i_cfg  (r_cfg),
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    ptm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ptm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    ptm_back #(
        .VOICES (VOICES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_cmd   (w_pop_cmd),
        .o_pop   (w_pop),
        .o_req   (w_req),
        .i_rsp   (w_rsp),
        .o_out   (o_out)
    );

endmodule
